@@ sv/pgsc_pkg.sv @@
package pgsc_pkg;

   // Fixed field widths.
   localparam int GAP_W   = 15;
   localparam int SIG_W   = 16;
   localparam int GAIN_W  = 16;
   localparam int DT_W    = 16;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 16;
   // Angular demand after rounding fits in this many bits.
   localparam int WRAW_W  = 24;
   // Width of the rate demand clamp applied before the curvature product.
   localparam int DCLAMP_W = 42;

   typedef enum logic [2:0] {
      CSR_TARGET_GAP   = 3'd0,
      CSR_GAP_GAIN     = 3'd1,
      CSR_SPEED_GAIN   = 3'd2,
      CSR_FF_GAIN      = 3'd3,
      CSR_STEER_GAIN   = 3'd4,
      CSR_MAX_LINEAR   = 3'd5,
      CSR_MAX_ANGULAR  = 3'd6,
      CSR_CURV_LIMIT   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_MUL,
      S_POST,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      OP_GAP   = 3'd0,
      OP_SPD   = 3'd1,
      OP_KP    = 3'd2,
      OP_KV    = 3'd3,
      OP_FF    = 3'd4,
      OP_STEER = 3'd5,
      OP_CURV  = 3'd6,
      OP_CD    = 3'd7
   } op_type;

endpackage

@@ sv/platoon_gap_and_steering_controller_unit.sv @@
// Platoon gap and steering controller.
//
// One item on the req_ channel carries a control tick: the measured gap, own
// and lead speed, the bearing to the vehicle ahead and the elapsed time. The
// block answers every item with exactly one item on the rsp_ channel holding
// the linear and angular commands and two flags. Both channels use valid and
// stall; an item moves at a clock edge with valid high and stall low.
//
// All eight products of a tick go through one shared bit-serial multiplier.
// Each product passes through a load state, a multiply state that consumes the
// 16-bit gain or time operand one bit at a time, and a state of rounding and
// accumulation. A new item is taken only once the block has returned to idle,
// after the previous result has been written into the output register.
//
// The result sits in an output register; the block accepts the next item
// while that result is still stalled, and only holds its final write back
// until the register is free. The user must write gains and limits via the csr_
// port only while the block is idle; the block does not enforce it. Synchronous
// reset restores the default gains and limits and clears both integrators.
module platoon_gap_and_steering_controller_unit #(
   parameter int INTEGRATOR_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [pgsc_pkg::CSR_AW-1:0]       csr_index,
   input  logic [pgsc_pkg::CSR_DW-1:0]       csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pgsc_pkg::GAP_W-1:0]        req_measured_gap,
   input  logic signed [pgsc_pkg::SIG_W-1:0] req_own_speed,
   input  logic signed [pgsc_pkg::SIG_W-1:0] req_lead_speed,
   input  logic signed [pgsc_pkg::SIG_W-1:0] req_bearing,
   input  logic [pgsc_pkg::DT_W-1:0]         req_elapsed_time,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pgsc_pkg::GAP_W-1:0]        rsp_linear_cmd,
   output logic signed [pgsc_pkg::SIG_W-1:0] rsp_angular_cmd,
   output logic                              rsp_linear_saturated,
   output logic                              rsp_curvature_limited
);
   import pgsc_pkg::*;

   localparam int IW      = INTEGRATOR_WIDTH;
   // Speed demand: three rounded Q8.8 products summed.
   localparam int DEM_W   = IW + 10;
   localparam int MCAND_W = (DEM_W > DCLAMP_W) ? DEM_W : DCLAMP_W;
   localparam int PW      = MCAND_W + GAIN_W + 1;
   localparam int BIT_CW  = $clog2(GAIN_W);

   localparam logic signed [PW-1:0] HALF16 = PW'(1) <<< 15;
   localparam logic signed [PW-1:0] HALF8  = PW'(1) <<< 7;
   localparam logic signed [PW-1:0] INT_MAX = (PW'(1) <<< (IW - 1)) - PW'(1);
   localparam logic signed [PW-1:0] INT_MIN = -(PW'(1) <<< (IW - 1));
   localparam logic signed [MCAND_W-1:0] D_MAX = MCAND_W'(1) <<< 40;
   localparam logic signed [PW-1:0] SIG_MAX = (PW'(1) <<< (SIG_W - 1)) - PW'(1);
   localparam logic signed [PW-1:0] SIG_MIN = -(PW'(1) <<< (SIG_W - 1));

   // Configuration registers.
   logic [GAP_W-1:0]  target_gap_ff, max_linear_ff, max_angular_ff;
   logic [GAIN_W-1:0] gap_gain_ff, speed_gain_ff, ff_gain_ff, steer_gain_ff, curv_limit_ff;

   // Captured item.
   logic [GAP_W-1:0]        gap_ff;
   logic signed [SIG_W-1:0] own_ff, lead_ff, bear_ff;
   logic [DT_W-1:0]         dt_ff;

   // Sequencer and serial multiplier.
   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [BIT_CW-1:0] bit_ff, bit_in;
   logic signed [MCAND_W-1:0] mcand_ff, mcand_in;
   logic [GAIN_W-1:0] mplier_ff, mplier_in;
   logic signed [PW-1:0] acc_ff, acc_in;

   // Working values.
   logic signed [IW-1:0]     gi_ff, gi_in, si_ff, si_in;
   logic signed [DEM_W-1:0]  dem_ff, dem_in;
   logic signed [WRAW_W-1:0] wraw_ff, wraw_in;
   logic [GAP_W-1:0]         lin_ff, lin_in;
   logic                     lsat_ff, lsat_in, curv_ff, curv_in;
   logic signed [SIG_W-1:0]  w_ff, w_in;

   // Result register.
   logic                    rv_ff, rv_in;
   logic [GAP_W-1:0]        rlin_ff;
   logic signed [SIG_W-1:0] rw_ff;
   logic                    rlsat_ff, rcurv_ff;
   logic                    load_out;

   logic                     accept;
   logic signed [PW-1:0]     r16, r8, isum, absw_sh;
   logic signed [MCAND_W-1:0] dem_ext, d_clamped;
   logic signed [SIG_W:0]    gap_err;
   logic signed [SIG_W:0]    spd_err;
   logic signed [WRAW_W-1:0] abs_w;
   logic signed [WRAW_W-1:0] max_ang_s;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_gap_ff <= GAP_W'(2048);
         gap_gain_ff   <= GAIN_W'(804);
         speed_gain_ff <= GAIN_W'(3558);
         ff_gain_ff    <= GAIN_W'(296);
         steer_gain_ff <= GAIN_W'(64);
         max_linear_ff <= GAP_W'(901);
         max_angular_ff <= GAP_W'(11633);
         curv_limit_ff <= GAIN_W'(1280);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TARGET_GAP:  target_gap_ff  <= csr_write_data[GAP_W-1:0];
            CSR_GAP_GAIN:    gap_gain_ff    <= csr_write_data;
            CSR_SPEED_GAIN:  speed_gain_ff  <= csr_write_data;
            CSR_FF_GAIN:     ff_gain_ff     <= csr_write_data;
            CSR_STEER_GAIN:  steer_gain_ff  <= csr_write_data;
            CSR_MAX_LINEAR:  max_linear_ff  <= csr_write_data[GAP_W-1:0];
            CSR_MAX_ANGULAR: max_angular_ff <= csr_write_data[GAP_W-1:0];
            CSR_CURV_LIMIT:  curv_limit_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gap_ff  <= req_measured_gap;
         own_ff  <= req_own_speed;
         lead_ff <= req_lead_speed;
         bear_ff <= req_bearing;
         dt_ff   <= req_elapsed_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_GAP;
         bit_ff   <= '0;
         gi_ff    <= '0;
         si_ff    <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         bit_ff   <= bit_in;
         gi_ff    <= gi_in;
         si_ff    <= si_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      dem_ff    <= dem_in;
      wraw_ff   <= wraw_in;
      lin_ff    <= lin_in;
      lsat_ff   <= lsat_in;
      curv_ff   <= curv_in;
      w_ff      <= w_in;
      if (load_out) begin
         rlin_ff  <= lin_ff;
         rw_ff    <= w_ff;
         rlsat_ff <= lsat_ff;
         rcurv_ff <= curv_ff;
      end
   end

   // Post-processing arithmetic on the finished product, and the operands prepared for loading.
   always_comb begin
      r16 = (acc_ff + HALF16) >>> 16;
      r8  = (acc_ff + HALF8) >>> 8;
      gap_err = $signed({2'b00, gap_ff}) - $signed({2'b00, target_gap_ff});
      spd_err = SIG_W'(0) + ((SIG_W+1)'(lead_ff) - (SIG_W+1)'(own_ff));
      dem_ext = MCAND_W'(dem_ff);
      if (dem_ext > D_MAX) begin
         d_clamped = D_MAX;
      end else if (dem_ext < -D_MAX) begin
         d_clamped = -D_MAX;
      end else begin
         d_clamped = dem_ext;
      end
      abs_w   = (wraw_ff < 0) ? -wraw_ff : wraw_ff;
      absw_sh = PW'(abs_w) <<< 8;
      max_ang_s = WRAW_W'({1'b0, max_angular_ff});
      if (op_ff == OP_GAP) begin
         isum = PW'(gi_ff) + r16;
      end else begin
         isum = PW'(si_ff) + r16;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      bit_in    = bit_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      gi_in     = gi_ff;
      si_in     = si_ff;
      dem_in    = dem_ff;
      wraw_in   = wraw_ff;
      lin_in    = lin_ff;
      lsat_in   = lsat_ff;
      curv_in   = curv_ff;
      w_in      = w_ff;
      rv_in     = rv_ff && rsp_stall;
      load_out  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOAD;
               op_in    = OP_GAP;
            end
         end
         S_LOAD: begin
            acc_in   = '0;
            bit_in   = '0;
            state_in = S_MUL;
            unique case (op_ff)
               OP_GAP:   begin mcand_in = MCAND_W'(gap_err);  mplier_in = dt_ff;         end
               OP_SPD:   begin mcand_in = MCAND_W'(spd_err);  mplier_in = dt_ff;         end
               OP_KP:    begin mcand_in = MCAND_W'(gi_ff);    mplier_in = gap_gain_ff;   end
               OP_KV:    begin mcand_in = MCAND_W'(si_ff);    mplier_in = speed_gain_ff; end
               OP_FF:    begin mcand_in = MCAND_W'(lead_ff);  mplier_in = ff_gain_ff;    end
               OP_STEER: begin mcand_in = MCAND_W'(bear_ff);  mplier_in = steer_gain_ff; end
               OP_CURV:  begin
                  mcand_in  = MCAND_W'({1'b0, lin_ff});
                  mplier_in = curv_limit_ff;
               end
               OP_CD:    begin mcand_in = d_clamped;          mplier_in = curv_limit_ff; end
               default: ;
            endcase
         end
         S_MUL: begin
            // Most significant multiplier bit first, one bit per cycle.
            acc_in    = (acc_ff <<< 1) + (mplier_ff[GAIN_W-1] ? PW'(mcand_ff) : PW'(0));
            mplier_in = mplier_ff << 1;
            bit_in    = bit_ff + BIT_CW'(1);
            if (bit_ff == BIT_CW'(GAIN_W - 1)) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            state_in = S_LOAD;
            op_in    = op_type'(op_ff + 3'd1);
            unique case (op_ff)
               OP_GAP, OP_SPD: begin
                  if (op_ff == OP_GAP) begin
                     gi_in = (isum > INT_MAX) ? IW'(INT_MAX) :
                             (isum < INT_MIN) ? IW'(INT_MIN) : IW'(isum);
                  end else begin
                     si_in = (isum > INT_MAX) ? IW'(INT_MAX) :
                             (isum < INT_MIN) ? IW'(INT_MIN) : IW'(isum);
                  end
               end
               OP_KP:        dem_in = DEM_W'(r8);
               OP_KV, OP_FF: dem_in = dem_ff + DEM_W'(r8);
               OP_STEER: begin
                  wraw_in = WRAW_W'(r8);
                  if (dem_ff > $signed(DEM_W'({1'b0, max_linear_ff}))) begin
                     lin_in  = max_linear_ff;
                     lsat_in = 1'b1;
                  end else if (dem_ff < 0) begin
                     lin_in  = '0;
                     lsat_in = 1'b1;
                  end else begin
                     lin_in  = GAP_W'(dem_ff);
                     lsat_in = 1'b0;
                  end
               end
               OP_CURV: begin
                  curv_in = (absw_sh > acc_ff);
                  if (wraw_ff > max_ang_s) begin
                     w_in = SIG_W'(max_ang_s);
                  end else if (wraw_ff < -max_ang_s) begin
                     w_in = SIG_W'(-max_ang_s);
                  end else begin
                     w_in = SIG_W'(wraw_ff);
                  end
               end
               OP_CD: begin
                  // The last product keeps its code while the result waits.
                  state_in = S_OUT;
                  op_in    = OP_CD;
                  if (curv_ff) begin
                     w_in = (r8 > SIG_MAX) ? SIG_W'(SIG_MAX) :
                            (r8 < SIG_MIN) ? SIG_W'(SIG_MIN) : SIG_W'(r8);
                  end
               end
               default: ;
            endcase
         end
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               load_out = 1'b1;
               rv_in    = 1'b1;
               state_in = S_IDLE;
               op_in    = OP_GAP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid             = rv_ff;
   assign rsp_linear_cmd        = rlin_ff;
   assign rsp_angular_cmd       = rw_ff;
   assign rsp_linear_saturated  = rlsat_ff;
   assign rsp_curvature_limited = rcurv_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_LOAD && op_ff == OP_GAP)
      else $error("item accepted without starting the sequence");

   a_out_after_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> op_ff == OP_CD)
      else $error("result stage reached before the last product");

   a_result_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff == S_OUT))
      else $error("result appeared without a finished sequence");

   a_linear_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POST && op_ff == OP_CURV) |-> lin_ff <= max_linear_ff)
      else $error("linear command above its limit");
`endif

endmodule

@@ test/tb_platoon_gap_and_steering_controller_unit.sv @@
`timescale 1ns / 1ps

module tb_platoon_gap_and_steering_controller_unit;
   import pgsc_pkg::*;

   // The integrator width is pinned here so that the command predictor saturates exactly
   // where the block does.
   localparam int INTEG_W = 32;
   localparam int N_PHASES = 6;
   localparam int RANDOM_TICKS_PER_PHASE = 180;
   // This margin covers a whole tick inside the block.
   localparam int SETTLE_CYCLES = 300;

   // One result item: the two commands and their flags.
   typedef struct packed {
      logic [GAP_W-1:0]        linear_cmd;
      logic signed [SIG_W-1:0] angular_cmd;
      logic                    linear_saturated;
      logic                    curvature_limited;
   } command_type;

   // One row of the directed table. Where "known" is set, the command is typed in by hand
   // and replaces the predicted one.
   typedef struct {
      logic [GAP_W-1:0]        gap;
      logic signed [SIG_W-1:0] own;
      logic signed [SIG_W-1:0] lead;
      logic signed [SIG_W-1:0] bear;
      logic [DT_W-1:0]         dt;
      bit                      known;
      command_type             cmd;
   } tick_row_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   logic [CSR_AW-1:0]       csr_index;
   logic [CSR_DW-1:0]       csr_write_data;
   logic                    req_valid;
   logic                    req_stall;
   logic [GAP_W-1:0]        req_measured_gap;
   logic signed [SIG_W-1:0] req_own_speed;
   logic signed [SIG_W-1:0] req_lead_speed;
   logic signed [SIG_W-1:0] req_bearing;
   logic [DT_W-1:0]         req_elapsed_time;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [GAP_W-1:0]        rsp_linear_cmd;
   logic signed [SIG_W-1:0] rsp_angular_cmd;
   logic                    rsp_linear_saturated;
   logic                    rsp_curvature_limited;

   platoon_gap_and_steering_controller_unit #(
      .INTEGRATOR_WIDTH(INTEG_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_measured_gap(req_measured_gap),
      .req_own_speed(req_own_speed),
      .req_lead_speed(req_lead_speed),
      .req_bearing(req_bearing),
      .req_elapsed_time(req_elapsed_time),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_linear_cmd(rsp_linear_cmd),
      .rsp_angular_cmd(rsp_angular_cmd),
      .rsp_linear_saturated(rsp_linear_saturated),
      .rsp_curvature_limited(rsp_curvature_limited)
   );

   // The testbench's own copy of the gains, the limits and both integrators.
   longint gain_reg [8];
   longint gap_acc;
   longint speed_acc;

   // Commands still owed by the block, oldest first.
   command_type pending_commands [$];
   int mismatch_count;
   // Percentages of cycles in which the sender idles and the receiver stalls.
   int send_idle_pct;
   int recv_stall_pct;

   always #5 clock = ~clock;

   // Rounds to nearest with ties towards plus infinity, then shifts; >>> on a longint floors.
   function automatic longint round_shift(longint x, int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint limit(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic void restore_defaults();
      gain_reg[CSR_TARGET_GAP]  = 2048;
      gain_reg[CSR_GAP_GAIN]    = 804;
      gain_reg[CSR_SPEED_GAIN]  = 3558;
      gain_reg[CSR_FF_GAIN]     = 296;
      gain_reg[CSR_STEER_GAIN]  = 64;
      gain_reg[CSR_MAX_LINEAR]  = 901;
      gain_reg[CSR_MAX_ANGULAR] = 11633;
      gain_reg[CSR_CURV_LIMIT]  = 1280;
      gap_acc = 0;
      speed_acc = 0;
   endfunction

   // Advances both integrators by one tick and returns the command that the tick should give.
   function automatic command_type control_tick(logic [GAP_W-1:0] gap,
                                                logic signed [SIG_W-1:0] own,
                                                logic signed [SIG_W-1:0] lead,
                                                logic signed [SIG_W-1:0] bear,
                                                logic [DT_W-1:0] dt);
      longint acc_hi;
      longint demand;
      longint lin;
      longint w_raw;
      longint w;
      longint abs_w;
      longint d;
      command_type c;
      acc_hi = (64'sd1 <<< (INTEG_W - 1)) - 1;
      c = '0;
      gap_acc = limit(gap_acc + round_shift((longint'(gap) - gain_reg[CSR_TARGET_GAP])
                      * longint'(dt), 16), -acc_hi - 1, acc_hi);
      speed_acc = limit(speed_acc + round_shift((longint'(lead) - longint'(own))
                        * longint'(dt), 16), -acc_hi - 1, acc_hi);
      demand = round_shift(gap_acc * gain_reg[CSR_GAP_GAIN], 8)
             + round_shift(speed_acc * gain_reg[CSR_SPEED_GAIN], 8)
             + round_shift(longint'(lead) * gain_reg[CSR_FF_GAIN], 8);
      lin = demand;
      if (demand > gain_reg[CSR_MAX_LINEAR]) begin
         lin = gain_reg[CSR_MAX_LINEAR];
         c.linear_saturated = 1'b1;
      end else if (demand < 0) begin
         lin = 0;
         c.linear_saturated = 1'b1;
      end
      w_raw = round_shift(longint'(bear) * gain_reg[CSR_STEER_GAIN], 8);
      w = limit(w_raw, -gain_reg[CSR_MAX_ANGULAR], gain_reg[CSR_MAX_ANGULAR]);
      abs_w = (w_raw < 0) ? -w_raw : w_raw;
      // The curvature test uses the linear command and ignores the angular limit.
      if (abs_w * 256 > gain_reg[CSR_CURV_LIMIT] * lin) begin
         d = limit(demand, -(64'sd1 <<< 40), 64'sd1 <<< 40);
         w = limit(round_shift(d * gain_reg[CSR_CURV_LIMIT], 8), -32768, 32767);
         c.curvature_limited = 1'b1;
      end
      c.linear_cmd = lin[GAP_W-1:0];
      c.angular_cmd = w[SIG_W-1:0];
      return c;
   endfunction

   task automatic write_gain(csr_index_type idx, longint value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value[CSR_DW-1:0];
      gain_reg[idx] = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Offers one tick to the block and records its expected command once it is accepted.
   // The task is entered and left at a falling edge.
   task automatic send_tick(tick_row_type row);
      command_type c;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_measured_gap = row.gap;
      req_own_speed = row.own;
      req_lead_speed = row.lead;
      req_bearing = row.bear;
      req_elapsed_time = row.dt;
      do @(posedge clock); while (req_stall);
      c = control_tick(row.gap, row.own, row.lead, row.bear, row.dt);
      pending_commands.push_back(row.known ? row.cmd : c);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Most ticks look like a real platoon at 50 Hz; the rest cover the whole range of every field.
   function automatic tick_row_type random_tick();
      tick_row_type r;
      r.known = 1'b0;
      r.cmd = '0;
      if ($urandom_range(99) < 70) begin
         r.gap = GAP_W'(limit(gain_reg[CSR_TARGET_GAP] + $urandom_range(4000) - 2000, 0, 32767));
         r.own = SIG_W'($urandom_range(8000));
         r.lead = SIG_W'($urandom_range(8000));
         r.bear = SIG_W'(longint'($urandom_range(8000)) - 4000);
         r.dt = DT_W'($urandom_range(2000));
      end else begin
         r.gap = GAP_W'($urandom);
         r.own = SIG_W'($urandom);
         r.lead = SIG_W'($urandom);
         r.bear = SIG_W'($urandom);
         r.dt = DT_W'($urandom);
      end
      return r;
   endfunction

   // The receiver stalls at random; the stall is changed only at the falling edge.
   always @(negedge clock) begin
      rsp_stall = (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   // Each result item taken is compared with the oldest command still owed.
   always @(posedge clock) begin
      command_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_commands.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Result item with no tick outstanding: lin %0d ang %0d sat %0b curv %0b",
                        rsp_linear_cmd, rsp_angular_cmd, rsp_linear_saturated,
                        rsp_curvature_limited);
         end else begin
            want = pending_commands.pop_front();
            if (rsp_linear_cmd !== want.linear_cmd || rsp_angular_cmd !== want.angular_cmd ||
                rsp_linear_saturated !== want.linear_saturated ||
                rsp_curvature_limited !== want.curvature_limited) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"Command mismatch: expected lin %0d ang %0d sat %0b curv %0b,",
                            " got lin %0d ang %0d sat %0b curv %0b"},
                           want.linear_cmd, want.angular_cmd, want.linear_saturated,
                           want.curvature_limited, rsp_linear_cmd, rsp_angular_cmd,
                           rsp_linear_saturated, rsp_curvature_limited);
            end
         end
      end
   end

   initial begin
      // Directed ticks under the reset gains. The first three start from clear integrators,
      // so their commands can be read off directly.
      tick_row_type directed [] = '{
         // Nothing moving: every output is zero.
         '{15'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1, '{15'd0, 16'sd0, 1'b0, 1'b0}},
         // A bearing with zero speed demand: the curvature rule forces zero turn rate.
         '{15'd0, 16'sd0, 16'sd0, 16'sd256, 16'd0, 1'b1, '{15'd0, 16'sd0, 1'b0, 1'b1}},
         '{15'd0, 16'sd0, 16'sd0, -16'sd256, 16'd0, 1'b1, '{15'd0, 16'sd0, 1'b0, 1'b1}},
         '{15'd32767, 16'sd0, 16'sd0, 16'sd0, 16'd65535, 1'b0, '0},
         '{15'd0, 16'sd0, 16'sd0, 16'sd0, 16'd65535, 1'b0, '0},
         '{15'd2048, 16'sd32767, 16'sd32767, 16'sd32767, 16'd0, 1'b0, '0},
         '{15'd2048, -16'sd32768, -16'sd32768, -16'sd32768, 16'd0, 1'b0, '0},
         '{15'd2048, -16'sd32768, 16'sd32767, 16'sd1000, 16'd65535, 1'b0, '0},
         '{15'd2048, 16'sd32767, -16'sd32768, -16'sd1000, 16'd65535, 1'b0, '0},
         '{15'd32767, -16'sd32768, 16'sd32767, 16'sd32767, 16'd65535, 1'b0, '0},
         '{15'd4096, 16'sd4096, 16'sd4096, 16'sd0, 16'd1311, 1'b0, '0},
         '{15'd2048, 16'sd0, 16'sd0, 16'sd1, 16'd1, 1'b0, '0},
         '{15'd0, 16'sd32767, -16'sd32768, -16'sd32768, 16'd65535, 1'b0, '0},
         '{15'd16384, 16'sd2000, 16'sd2500, 16'sd200, 16'd1311, 1'b0, '0},
         '{15'd1, 16'sd1, -16'sd1, -16'sd1, 16'd32768, 1'b0, '0}
      };
      // Register values for each phase, in index order. Phase 0 keeps the reset values.
      longint phase_gains [N_PHASES][8] = '{
         '{2048, 804, 3558, 296, 64, 901, 11633, 1280},
         '{32767, 65535, 65535, 65535, 65535, 32767, 32767, 65535},
         '{0, 0, 0, 0, 0, 0, 0, 0},
         '{2048, 804, 3558, 296, 64, 901, 11633, 1280},
         '{3000, 200, 1000, 256, 512, 20000, 4000, 300},
         '{0, 0, 0, 0, 0, 0, 0, 0}
      };
      // Idling per phase as sender and receiver percentages.
      int idle_mode [N_PHASES][2] = '{'{0, 0}, '{81, 0}, '{0, 81}, '{7, 7}, '{81, 0}, '{0, 81}};
      int wait_cycles;

      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_TARGET_GAP;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_measured_gap = '0;
      req_own_speed = '0;
      req_lead_speed = '0;
      req_bearing = '0;
      req_elapsed_time = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      restore_defaults();
      // The last phase draws its settings at random.
      for (int k = 0; k < 8; k++)
         phase_gains[N_PHASES-1][k] = (k == CSR_TARGET_GAP || k == CSR_MAX_LINEAR ||
                                       k == CSR_MAX_ANGULAR) ? $urandom_range(32767)
                                                             : $urandom_range(65535);
      repeat (8) @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < N_PHASES; p++) begin
         // Registers change only while the block is idle: every command is back and the
         // block has had time to finish whatever it was doing.
         wait_cycles = 0;
         while (pending_commands.size() != 0 && wait_cycles < 100000) begin
            @(negedge clock);
            wait_cycles++;
         end
         repeat (SETTLE_CYCLES) @(negedge clock);
         send_idle_pct = idle_mode[p][0];
         recv_stall_pct = idle_mode[p][1];
         if (p > 0)
            for (int k = 0; k < 8; k++) write_gain(csr_index_type'(k), phase_gains[p][k]);
         if (p == 0)
            foreach (directed[i]) send_tick(directed[i]);
         for (int n = 0; n < RANDOM_TICKS_PER_PHASE; n++) send_tick(random_tick());
      end

      wait_cycles = 0;
      while (pending_commands.size() != 0 && wait_cycles < 100000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_commands.size() == 0) begin
         $display("platoon_gap_and_steering_controller_unit verification clean");
      end else begin
         $display("platoon_gap_and_steering_controller_unit verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #12_000_000;
      $display("platoon_gap_and_steering_controller_unit verification failed");
      $finish;
   end

endmodule

@@ platoon_gap_and_steering_controller_unit.f @@
sv/pgsc_pkg.sv
sv/platoon_gap_and_steering_controller_unit.sv
test/tb_platoon_gap_and_steering_controller_unit.sv
